@@ hdl/tsi_pkg.sv @@
package tsi_pkg;

  localparam int unsigned SampleW = 8;
  localparam int unsigned LevelW = 5;
  localparam int unsigned FadeW = 4;
  localparam int unsigned AxisW = 2;
  localparam int unsigned NumAxes = 3;

  localparam int unsigned PwmLevelsDefault = 20;
  localparam int unsigned FadeDivideDefault = 10;

  localparam logic [SampleW-1:0] StartByte = 8'hFF;
  localparam logic [SampleW-1:0] LimitMax = 8'hFE;
  localparam logic [AxisW-1:0] AxisFirst = 2'd1;
  localparam logic [AxisW-1:0] AxisLast = 2'd3;
  localparam logic [SampleW-1:0] LimitReset = 8'd150;
  localparam logic [SampleW-1:0] RestResetX = 8'd128;
  localparam logic [SampleW-1:0] RestResetY = 8'd128;
  localparam logic [SampleW-1:0] RestResetZ = 8'd157;

  typedef enum logic [1:0] {
    KIND_SAMPLE = 2'd0,
    KIND_PWM    = 2'd1,
    KIND_RX     = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    CFG_REST_X = 2'd0,
    CFG_REST_Y = 2'd1,
    CFG_REST_Z = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]                      kind;
    logic [NumAxes-1:0][SampleW-1:0] accel;
    logic [SampleW-1:0]              rx_byte;
  } item_t;

  typedef struct packed {
    logic               has_result;
    logic               echo;
    logic [2:0]         leds;
    logic [AxisW-1:0]   axis;
    logic [SampleW-1:0] limit;
  } res_req_t;

endpackage

@@ hdl/three_axis_shock_indicator.sv @@
// Flow: an item is registered on acceptance and processed from that register;
//   its result is registered in the output stage when the item is consumed,
//   which waits while that stage owes beats. Throughput: one item per cycle
//   unless the input stalls; a pwm result takes one output beat, an echo
//   holds the result register for three beats, limited by the output side.
// Reset (async, active low): brightness, phases and counters clear, trip
//   limits go to 150, rest levels to 128/128/157, no beat pending.
module three_axis_shock_indicator #(
  parameter int unsigned PWM_LEVELS = tsi_pkg::PwmLevelsDefault,
  parameter int unsigned FADE_DIVIDE = tsi_pkg::FadeDivideDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration write port
  input  logic                         cfg_we_i,
  input  logic [1:0]                   cfg_index_i,
  input  logic [tsi_pkg::SampleW-1:0]  cfg_data_i,
  // event channel
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [1:0]                   kind_i,
  input  logic [tsi_pkg::SampleW-1:0]  accel_x_i,
  input  logic [tsi_pkg::SampleW-1:0]  accel_y_i,
  input  logic [tsi_pkg::SampleW-1:0]  accel_z_i,
  input  logic [tsi_pkg::SampleW-1:0]  rx_byte_i,
  // result channel
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [2:0]                   led_bits_o,
  output logic                         tx_valid_o,
  output logic [tsi_pkg::SampleW-1:0]  tx_byte_o,
  output logic                         last_o
);

  logic [tsi_pkg::NumAxes-1:0][tsi_pkg::SampleW-1:0] rest_q;
  tsi_pkg::item_t    item_q;
  logic              item_valid_q;
  logic              accept;
  logic              fire;
  logic              out_free;
  tsi_pkg::res_req_t req;

  // Rest levels: plain write port, unknown index dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rest_q[0] <= tsi_pkg::RestResetX;
      rest_q[1] <= tsi_pkg::RestResetY;
      rest_q[2] <= tsi_pkg::RestResetZ;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        tsi_pkg::CFG_REST_X: rest_q[0] <= cfg_data_i;
        tsi_pkg::CFG_REST_Y: rest_q[1] <= cfg_data_i;
        tsi_pkg::CFG_REST_Z: rest_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // The held item is consumed unless it produces a result and the result
  // register still owes beats of an earlier one. Items without results
  // (samples, most bytes) never wait on the output side.
  assign fire = item_valid_q && (!req.has_result || out_free);
  assign in_stall_o = item_valid_q && !fire;
  assign accept = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (accept) begin
      item_valid_q <= 1'b1;
    end else if (fire) begin
      item_valid_q <= 1'b0;
    end
  end

  // Input beat payload: load on accept, no reset needed
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.kind <= kind_i;
      item_q.accel <= {accel_z_i, accel_y_i, accel_x_i};
      item_q.rx_byte <= rx_byte_i;
    end
  end

  tsi_core #(
    .PWM_LEVELS (PWM_LEVELS),
    .FADE_DIVIDE(FADE_DIVIDE)
  ) u_core (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .fire_i(fire),
    .item_i(item_q),
    .rest_i(rest_q),
    .req_o (req)
  );

  tsi_out u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (fire),
    .req_i      (req),
    .free_o     (out_free),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .led_bits_o (led_bits_o),
    .tx_valid_o (tx_valid_o),
    .tx_byte_o  (tx_byte_o),
    .last_o     (last_o)
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   in_stall_o |-> item_valid_q && req.has_result && !out_free)
    else $error("input stalled without a blocking result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   item_valid_q && !req.has_result |-> !in_stall_o)
    else $error("resultless item held back");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   fire && req.has_result |=> out_valid_o)
    else $error("result lost after processing");

endmodule

@@ hdl/tsi_core.sv @@
module tsi_core #(
  parameter int unsigned PWM_LEVELS = tsi_pkg::PwmLevelsDefault,
  parameter int unsigned FADE_DIVIDE = tsi_pkg::FadeDivideDefault
) (
  input  logic                                                clk_i,
  input  logic                                                rst_ni,
  input  logic                                                fire_i,
  input  tsi_pkg::item_t                                      item_i,
  input  logic [tsi_pkg::NumAxes-1:0][tsi_pkg::SampleW-1:0]   rest_i,
  output tsi_pkg::res_req_t                                   req_o
);

  localparam logic [tsi_pkg::LevelW-1:0] LevelFull = tsi_pkg::LevelW'(PWM_LEVELS);
  localparam logic [tsi_pkg::FadeW-1:0] FadeLimit = tsi_pkg::FadeW'(FADE_DIVIDE);

  typedef enum logic [1:0] {
    PH_START = 2'd0,
    PH_AXIS  = 2'd1,
    PH_LIMIT = 2'd2
  } phase_e;

  logic [tsi_pkg::NumAxes-1:0][tsi_pkg::LevelW-1:0]  level_q, level_d;
  logic [tsi_pkg::NumAxes-1:0][tsi_pkg::SampleW-1:0] limit_q, limit_d;
  logic [tsi_pkg::NumAxes-1:0][tsi_pkg::SampleW-1:0] diff;
  logic [tsi_pkg::NumAxes-1:0][tsi_pkg::LevelW-1:0]  level_hit;
  logic [tsi_pkg::LevelW-1:0]  pwm_q, pwm_d, pwm_inc;
  logic [tsi_pkg::FadeW-1:0]   fade_q, fade_d, fade_inc;
  phase_e                      phase_q, phase_d;
  logic [tsi_pkg::AxisW-1:0]   axis_q, axis_d;

  // Per-axis deviation and trip check
  always_comb begin
    for (int i = 0; i < tsi_pkg::NumAxes; i++) begin
      diff[i] = (item_i.accel[i] > rest_i[i]) ? item_i.accel[i] - rest_i[i]
                                              : rest_i[i] - item_i.accel[i];
      level_hit[i] = (diff[i] >= limit_q[i]) ? LevelFull : level_q[i];
    end
  end

  assign fade_inc = fade_q + 1'b1;
  assign pwm_inc = pwm_q + 1'b1;

  always_comb begin
    level_d = level_q;
    limit_d = limit_q;
    pwm_d = pwm_q;
    fade_d = fade_q;
    phase_d = phase_q;
    axis_d = axis_q;
    req_o = '0;
    case (item_i.kind)
      tsi_pkg::KIND_SAMPLE: begin
        level_d = level_hit;
        if (fade_inc >= FadeLimit) begin
          fade_d = '0;
          for (int i = 0; i < tsi_pkg::NumAxes; i++) begin
            if (level_hit[i] != '0) begin
              level_d[i] = level_hit[i] - 1'b1;
            end
          end
        end else begin
          fade_d = fade_inc;
        end
      end
      tsi_pkg::KIND_PWM: begin
        req_o.has_result = 1'b1;
        for (int i = 0; i < tsi_pkg::NumAxes; i++) begin
          req_o.leds[i] = pwm_q < level_q[i];
        end
        pwm_d = (pwm_inc >= LevelFull) ? '0 : pwm_inc;
      end
      tsi_pkg::KIND_RX: begin
        case (phase_q)
          PH_START: begin
            if (item_i.rx_byte == tsi_pkg::StartByte) begin
              phase_d = PH_AXIS;
            end
          end
          PH_AXIS: begin
            if (item_i.rx_byte >= 8'(tsi_pkg::AxisFirst) &&
                item_i.rx_byte <= 8'(tsi_pkg::AxisLast)) begin
              axis_d = item_i.rx_byte[tsi_pkg::AxisW-1:0];
              phase_d = PH_LIMIT;
            end else begin
              phase_d = PH_START;
            end
          end
          PH_LIMIT: begin
            phase_d = PH_START;
            if (item_i.rx_byte <= tsi_pkg::LimitMax) begin
              if (axis_q != '0) begin
                limit_d[axis_q - 1'b1] = item_i.rx_byte;
              end
              req_o.has_result = 1'b1;
              req_o.echo = 1'b1;
              req_o.axis = axis_q;
              req_o.limit = item_i.rx_byte;
            end
          end
          default: phase_d = PH_START;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q <= '0;
      limit_q <= {tsi_pkg::NumAxes{tsi_pkg::LimitReset}};
      pwm_q <= '0;
      fade_q <= '0;
      phase_q <= PH_START;
      axis_q <= '0;
    end else if (fire_i) begin
      level_q <= level_d;
      limit_q <= limit_d;
      pwm_q <= pwm_d;
      fade_q <= fade_d;
      phase_q <= phase_d;
      axis_q <= axis_d;
    end
  end

  for (genvar g = 0; g < tsi_pkg::NumAxes; g++) begin : g_lvl_chk
    assert property (@(posedge clk_i) disable iff (!rst_ni) level_q[g] <= LevelFull)
      else $error("brightness above full scale");
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) pwm_q < LevelFull)
    else $error("pwm phase out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   phase_q == PH_LIMIT |-> axis_q != '0)
    else $error("limit phase without a pending axis");

endmodule

@@ hdl/tsi_out.sv @@
module tsi_out (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          fire_i,
  input  tsi_pkg::res_req_t             req_i,
  output logic                          free_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [2:0]                    led_bits_o,
  output logic                          tx_valid_o,
  output logic [tsi_pkg::SampleW-1:0]   tx_byte_o,
  output logic                          last_o
);

  typedef enum logic [1:0] {
    BEAT_START = 2'd0,
    BEAT_AXIS  = 2'd1,
    BEAT_LIMIT = 2'd2
  } beat_e;

  logic                         valid_q;
  logic                         echo_q;
  logic [2:0]                   leds_q;
  logic [tsi_pkg::AxisW-1:0]    axis_q;
  logic [tsi_pkg::SampleW-1:0]  limit_q;
  beat_e                        beat_q;
  logic                         take;

  assign take = valid_q && !out_stall_i;
  assign last_o = !echo_q || beat_q == BEAT_LIMIT;
  assign free_o = !valid_q || (take && last_o);

  assign out_valid_o = valid_q;
  assign led_bits_o = echo_q ? 3'b000 : leds_q;
  assign tx_valid_o = echo_q;

  always_comb begin
    tx_byte_o = '0;
    if (echo_q) begin
      case (beat_q)
        BEAT_START: tx_byte_o = tsi_pkg::StartByte;
        BEAT_AXIS:  tx_byte_o = tsi_pkg::SampleW'(axis_q);
        BEAT_LIMIT: tx_byte_o = limit_q;
        default:    tx_byte_o = '0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      echo_q <= 1'b0;
      beat_q <= BEAT_START;
    end else if (fire_i && req_i.has_result) begin
      valid_q <= 1'b1;
      echo_q <= req_i.echo;
      beat_q <= BEAT_START;
    end else if (take) begin
      if (last_o) begin
        valid_q <= 1'b0;
      end else begin
        beat_q <= (beat_q == BEAT_START) ? BEAT_AXIS : BEAT_LIMIT;
      end
    end
  end

  // Payload holds until the next result is loaded
  always_ff @(posedge clk_i) begin
    if (fire_i && req_i.has_result) begin
      leds_q <= req_i.leds;
      axis_q <= req_i.axis;
      limit_q <= req_i.limit;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   fire_i && req_i.has_result |-> free_o)
    else $error("result register overwritten before last beat");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   valid_q && !echo_q |-> beat_q == BEAT_START)
    else $error("pwm result advanced beat counter");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   take && echo_q && beat_q == BEAT_START && !fire_i
                   |=> valid_q && beat_q == BEAT_AXIS)
    else $error("echo beat sequence broken");

endmodule

@@ tb/sv/tb_three_axis_shock_indicator.sv @@
`timescale 1ns / 1ps

module tb_three_axis_shock_indicator;

  localparam int unsigned PwmLevels = tsi_pkg::PwmLevelsDefault;
  localparam int unsigned FadeDivide = tsi_pkg::FadeDivideDefault;

  // kind code that the block must ignore
  localparam logic [1:0] KindUnused = 2'd3;

  // packet parser phases
  localparam logic [1:0] ParseIdle  = 2'd0;
  localparam logic [1:0] ParseAxis  = 2'd1;
  localparam logic [1:0] ParseLimit = 2'd2;

  localparam int unsigned SettleCycles = 6;
  localparam int unsigned HoldCycles = 64;
  localparam int unsigned SegmentItems = 56;
  localparam int unsigned NumSegments = 6;
  localparam int unsigned ReportLimit = 10;
  localparam int unsigned TimeoutNs = 2_000_000;

  typedef struct packed {
    logic [2:0] leds;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       last;
  } beat_t;

  // one directed row; typed rows carry their expected beats in plain sight
  typedef struct {
    logic [1:0]  kind;
    logic [7:0]  x;
    logic [7:0]  y;
    logic [7:0]  z;
    logic [7:0]  rx;
    bit          typed;
    int unsigned n_typed;
    logic [2:0]  leds;
    logic [1:0]  axis;
  } vector_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we_i = 1'b0;
  logic [1:0] cfg_index_i = '0;
  logic [7:0] cfg_data_i = '0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [1:0] kind_i = '0;
  logic [7:0] accel_x_i = '0;
  logic [7:0] accel_y_i = '0;
  logic [7:0] accel_z_i = '0;
  logic [7:0] rx_byte_i = '0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [2:0] led_bits_o;
  logic       tx_valid_o;
  logic [7:0] tx_byte_o;
  logic       last_o;

  three_axis_shock_indicator #(
    .PWM_LEVELS (PwmLevels),
    .FADE_DIVIDE(FadeDivide)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .kind_i     (kind_i),
    .accel_x_i  (accel_x_i),
    .accel_y_i  (accel_y_i),
    .accel_z_i  (accel_z_i),
    .rx_byte_i  (rx_byte_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .led_bits_o (led_bits_o),
    .tx_valid_o (tx_valid_o),
    .tx_byte_o  (tx_byte_o),
    .last_o     (last_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // shadow of the indicator state
  logic [7:0] rest_lvl [3];
  logic [4:0] brightness [3];
  logic [7:0] trip_lim [3];
  logic [4:0] pwm_phase_q;
  logic [3:0] fade_cnt;
  logic [1:0] parse_st;
  logic [1:0] axis_held;

  beat_t due_beats [$];
  int unsigned fault_count = 0;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_req = 0;
  int unsigned hold_ack = 0;
  int unsigned hold_left = 0;

  // Advance the shadow state by one event and return the beats it produces.
  function automatic int advance_indicator(input tsi_pkg::item_t it, output beat_t res [3]);
    logic [7:0] gap;
    logic [2:0] leds;
    int n;
    n = 0;
    res = '{default: '0};
    case (it.kind)
      tsi_pkg::KIND_SAMPLE: begin
        for (int i = 0; i < 3; i++) begin
          gap = (it.accel[i] > rest_lvl[i]) ? it.accel[i] - rest_lvl[i]
                                            : rest_lvl[i] - it.accel[i];
          if (gap >= trip_lim[i]) brightness[i] = 5'(PwmLevels);
        end
        fade_cnt = fade_cnt + 4'd1;
        if (fade_cnt >= FadeDivide) begin
          fade_cnt = '0;
          for (int i = 0; i < 3; i++)
            if (brightness[i] != '0) brightness[i] = brightness[i] - 5'd1;
        end
      end
      tsi_pkg::KIND_PWM: begin
        for (int i = 0; i < 3; i++) leds[i] = (pwm_phase_q < brightness[i]);
        res[0] = '{leds: leds, tx_valid: 1'b0, tx_byte: '0, last: 1'b1};
        n = 1;
        pwm_phase_q = pwm_phase_q + 5'd1;
        if (pwm_phase_q >= PwmLevels) pwm_phase_q = '0;
      end
      tsi_pkg::KIND_RX: begin
        case (parse_st)
          ParseIdle: begin
            if (it.rx_byte == tsi_pkg::StartByte) parse_st = ParseAxis;
          end
          ParseAxis: begin
            // a second start byte here is a bad axis, not a restart
            if (it.rx_byte >= tsi_pkg::AxisFirst && it.rx_byte <= tsi_pkg::AxisLast) begin
              axis_held = it.rx_byte[1:0];
              parse_st = ParseLimit;
            end else begin
              parse_st = ParseIdle;
            end
          end
          ParseLimit: begin
            parse_st = ParseIdle;
            if (it.rx_byte <= tsi_pkg::LimitMax) begin
              trip_lim[axis_held - tsi_pkg::AxisFirst] = it.rx_byte;
              res[0] = '{leds: '0, tx_valid: 1'b1, tx_byte: tsi_pkg::StartByte,
                         last: 1'b0};
              res[1] = '{leds: '0, tx_valid: 1'b1, tx_byte: {6'd0, axis_held}, last: 1'b0};
              res[2] = '{leds: '0, tx_valid: 1'b1, tx_byte: it.rx_byte, last: 1'b1};
              n = 3;
            end
          end
          default: parse_st = ParseIdle;
        endcase
      end
      default: ;  // unused kind: no beat, no state change
    endcase
    return n;
  endfunction

  function automatic tsi_pkg::item_t make_item(input logic [1:0] kind, input logic [7:0] rx);
    tsi_pkg::item_t it;
    it.kind = kind;
    for (int i = 0; i < 3; i++) it.accel[i] = 8'($urandom_range(255));
    it.rx_byte = rx;
    return it;
  endfunction

  // Offer one beat, idling first at the current rate; hold it until taken.
  task automatic drive_event(input tsi_pkg::item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i <= it.kind;
    accel_x_i <= it.accel[0];
    accel_y_i <= it.accel[1];
    accel_z_i <= it.accel[2];
    rx_byte_i <= it.rx_byte;
    do begin
      @(posedge clk_i);
    end while (in_stall_o);
  endtask

  task automatic send_checked(input tsi_pkg::item_t it);
    beat_t res [3];
    int n;
    drive_event(it);
    n = advance_indicator(it, res);
    for (int k = 0; k < n; k++) due_beats.push_back(res[k]);
  endtask

  // Drop valid, wait for every due beat, then let the block go quiet.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (due_beats.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic load_rest_levels(input logic [7:0] x, input logic [7:0] y,
                                  input logic [7:0] z);
    tsi_pkg::cfg_idx_e regs [3];
    logic [7:0] vals [3];
    regs = '{tsi_pkg::CFG_REST_X, tsi_pkg::CFG_REST_Y, tsi_pkg::CFG_REST_Z};
    vals = '{x, y, z};
    for (int i = 0; i < 3; i++) begin
      cfg_we_i <= 1'b1;
      cfg_index_i <= regs[i];
      cfg_data_i <= vals[i];
      rest_lvl[i] = vals[i];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  // Mostly sample and pwm ticks plus well-formed packets; the rest is noise:
  // bad axis, dropped limit, stray bytes and the unused kind.
  task automatic run_random(input int unsigned count);
    int unsigned sent;
    int unsigned pick;
    logic [7:0] limit;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(99);
      if (pick < 35) begin
        send_checked(make_item(tsi_pkg::KIND_SAMPLE, 8'($urandom_range(255))));
        sent++;
      end else if (pick < 70) begin
        send_checked(make_item(tsi_pkg::KIND_PWM, 8'($urandom_range(255))));
        sent++;
      end else if (pick < 92) begin
        limit = $urandom_range(1) ? 8'($urandom_range(60))
                                  : 8'($urandom_range(tsi_pkg::LimitMax));
        send_checked(make_item(tsi_pkg::KIND_RX, tsi_pkg::StartByte));
        send_checked(make_item(tsi_pkg::KIND_RX,
                               8'($urandom_range(tsi_pkg::AxisLast, tsi_pkg::AxisFirst))));
        send_checked(make_item(tsi_pkg::KIND_RX, limit));
        sent += 3;
      end else begin
        case ($urandom_range(3))
          0: begin
            send_checked(make_item(tsi_pkg::KIND_RX, tsi_pkg::StartByte));
            send_checked(make_item(tsi_pkg::KIND_RX,
                                   $urandom_range(1) ? 8'd0 : 8'($urandom_range(255, 4))));
            sent += 2;
          end
          1: begin
            send_checked(make_item(tsi_pkg::KIND_RX, tsi_pkg::StartByte));
            send_checked(make_item(tsi_pkg::KIND_RX,
                                   8'($urandom_range(tsi_pkg::AxisLast,
                                                     tsi_pkg::AxisFirst))));
            send_checked(make_item(tsi_pkg::KIND_RX, tsi_pkg::StartByte));
            sent += 3;
          end
          2: begin
            send_checked(make_item(tsi_pkg::KIND_RX, 8'($urandom_range(255))));
            sent++;
          end
          default: begin
            send_checked(make_item(KindUnused, 8'($urandom_range(255))));
            sent++;
          end
        endcase
      end
    end
  endtask

  // Result side: check each taken beat, then pick the stall for the next edge.
  always @(posedge clk_i) begin : result_side
    beat_t seen;
    beat_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        seen = '{leds: led_bits_o, tx_valid: tx_valid_o, tx_byte: tx_byte_o, last: last_o};
        if (due_beats.size() == 0) begin
          fault_count++;
          if (fault_count <= ReportLimit)
            $display("unexpected beat: leds=%0h tx_valid=%0b tx_byte=%02h last=%0b",
                     seen.leds, seen.tx_valid, seen.tx_byte, seen.last);
        end else begin
          want = due_beats.pop_front();
          if (seen.leds !== want.leds || seen.tx_valid !== want.tx_valid ||
              seen.tx_byte !== want.tx_byte || seen.last !== want.last) begin
            fault_count++;
            if (fault_count <= ReportLimit)
              $display("beat mismatch: expected leds=%0h tx_valid=%0b tx_byte=%02h last=%0b, %s",
                       want.leds, want.tx_valid, want.tx_byte, want.last,
                       $sformatf("got leds=%0h tx_valid=%0b tx_byte=%02h last=%0b",
                                 seen.leds, seen.tx_valid, seen.tx_byte, seen.last));
          end
        end
      end
      // a hold request stalls the output for a long stretch
      if (hold_req != hold_ack) begin
        hold_ack <= hold_req;
        hold_left <= HoldCycles;
        out_stall_i <= 1'b1;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  vector_t directed_rows [0:24] = '{
    // after reset every LED is dark
    '{tsi_pkg::KIND_PWM,    8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 1, 3'b000, 2'd0},
    // sample extremes: only z reaches the default limit
    '{tsi_pkg::KIND_SAMPLE, 8'h00, 8'hFF, 8'h00, 8'h00, 1'b0, 0, 3'b000, 2'd0},
    '{tsi_pkg::KIND_PWM,    8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 1, 3'b100, 2'd0},
    // zero limit on x: x then trips on every sample tick
    '{tsi_pkg::KIND_RX,     8'h00, 8'h00, 8'h00, 8'hFF, 1'b0, 0, 3'b000, 2'd0},
    '{tsi_pkg::KIND_RX,     8'h00, 8'h00, 8'h00, 8'h01, 1'b0, 0, 3'b000, 2'd0},
    '{tsi_pkg::KIND_RX,     8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 3, 3'b000,
      tsi_pkg::AxisFirst},
    '{tsi_pkg::KIND_SAMPLE, 8'h80, 8'h80, 8'h9D, 8'h00, 1'b0, 0, 3'b000, 2'd0},
    '{tsi_pkg::KIND_PWM,    8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 1, 3'b101, 2'd0},
    // start byte in the axis slot is a bad axis, next byte is ignored
    '{tsi_pkg::KIND_RX,     8'h00, 8'h00, 8'h00, 8'hFF, 1'b0, 0, 3'b000, 2'd0},
    '{tsi_pkg::KIND_RX,     8'h00, 8'h00, 8'h00, 8'hFF, 1'b1, 0, 3'b000, 2'd0},
    '{tsi_pkg::KIND_RX,     8'h00, 8'h00, 8'h00, 8'h03, 1'b1, 0, 3'b000, 2'd0},
    // axis zero is a bad axis
    '{tsi_pkg::KIND_RX,     8'h00, 8'h00, 8'h00, 8'hFF, 1'b0, 0, 3'b000, 2'd0},
    '{tsi_pkg::KIND_RX,     8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 0, 3'b000, 2'd0},
    // start byte in the limit slot drops the packet
    '{tsi_pkg::KIND_RX,     8'h00, 8'h00, 8'h00, 8'hFF, 1'b0, 0, 3'b000, 2'd0},
    '{tsi_pkg::KIND_RX,     8'h00, 8'h00, 8'h00, 8'h03, 1'b0, 0, 3'b000, 2'd0},
    '{tsi_pkg::KIND_RX,     8'h00, 8'h00, 8'h00, 8'hFF, 1'b1, 0, 3'b000, 2'd0},
    // largest limit on z
    '{tsi_pkg::KIND_RX,     8'h00, 8'h00, 8'h00, 8'hFF, 1'b0, 0, 3'b000, 2'd0},
    '{tsi_pkg::KIND_RX,     8'h00, 8'h00, 8'h00, 8'h03, 1'b0, 0, 3'b000, 2'd0},
    '{tsi_pkg::KIND_RX,     8'h00, 8'h00, 8'h00, 8'hFE, 1'b1, 3, 3'b000,
      tsi_pkg::AxisLast},
    // zero limit on y
    '{tsi_pkg::KIND_RX,     8'h00, 8'h00, 8'h00, 8'hFF, 1'b0, 0, 3'b000, 2'd0},
    '{tsi_pkg::KIND_RX,     8'h00, 8'h00, 8'h00, 8'h02, 1'b0, 0, 3'b000, 2'd0},
    '{tsi_pkg::KIND_RX,     8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 3, 3'b000, 2'd2},
    // unused kind with every payload bit set
    '{KindUnused,           8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 0, 3'b000, 2'd0},
    '{tsi_pkg::KIND_SAMPLE, 8'hFF, 8'hFF, 8'hFF, 8'h00, 1'b0, 0, 3'b000, 2'd0},
    '{tsi_pkg::KIND_PWM,    8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 0, 3'b000, 2'd0}
  };

  initial begin : stimulus
    tsi_pkg::item_t it;
    beat_t res [3];
    int n;

    rest_lvl = '{tsi_pkg::RestResetX, tsi_pkg::RestResetY, tsi_pkg::RestResetZ};
    brightness = '{default: '0};
    trip_lim = '{default: tsi_pkg::LimitReset};
    pwm_phase_q = '0;
    fade_cnt = '0;
    parse_st = ParseIdle;
    axis_held = '0;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed rows run on the reset rest levels
    send_idle_pct = 18;
    recv_idle_pct = 69;
    foreach (directed_rows[r]) begin
      it.kind = directed_rows[r].kind;
      it.accel[0] = directed_rows[r].x;
      it.accel[1] = directed_rows[r].y;
      it.accel[2] = directed_rows[r].z;
      it.rx_byte = directed_rows[r].rx;
      drive_event(it);
      n = advance_indicator(it, res);
      if (directed_rows[r].typed) begin
        if (directed_rows[r].n_typed == 1) begin
          due_beats.push_back('{leds: directed_rows[r].leds, tx_valid: 1'b0,
                                tx_byte: '0, last: 1'b1});
        end else if (directed_rows[r].n_typed == 3) begin
          due_beats.push_back('{leds: '0, tx_valid: 1'b1, tx_byte: tsi_pkg::StartByte,
                                last: 1'b0});
          due_beats.push_back('{leds: '0, tx_valid: 1'b1,
                                tx_byte: {6'd0, directed_rows[r].axis}, last: 1'b0});
          due_beats.push_back('{leds: '0, tx_valid: 1'b1, tx_byte: it.rx_byte, last: 1'b1});
        end
      end else begin
        for (int k = 0; k < n; k++) due_beats.push_back(res[k]);
      end
    end
    wait_drained();

    // random segments: new rest levels each time, idling pattern every two
    for (int seg = 0; seg < NumSegments; seg++) begin
      case (seg)
        0: load_rest_levels(8'h00, 8'h00, 8'h00);
        1: load_rest_levels(8'hFF, 8'hFF, 8'hFF);
        3: load_rest_levels(8'h00, 8'hFF, 8'h80);
        5: load_rest_levels(tsi_pkg::RestResetX, tsi_pkg::RestResetY, tsi_pkg::RestResetZ);
        default: load_rest_levels(8'($urandom_range(255)), 8'($urandom_range(255)),
                                  8'($urandom_range(255)));
      endcase
      if (seg < 2) begin
        send_idle_pct = 18;
        recv_idle_pct = 69;
      end else if (seg < 4) begin
        send_idle_pct = 69;
        recv_idle_pct = 18;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      // back-pressure: hold the output while the sender keeps streaming
      if (seg == 4) hold_req <= hold_req + 1;
      run_random(SegmentItems);
      wait_drained();
    end

    if (fault_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #(TimeoutNs);
    $display("status: fail");
    $finish;
  end

endmodule
